// ----- design/htfd_pkg.sv -----
package htfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned RawW  = 2 * ByteW;
  localparam int unsigned SpanW = 15;
  localparam int unsigned ProdW = RawW + SpanW;
  localparam int unsigned TempW = 15;
  localparam int unsigned HumW  = 14;

  localparam logic [ByteW-1:0] CrcPoly = 8'h31;
  localparam logic [ByteW-1:0] CrcInit = 8'hFF;

  localparam logic [SpanW-1:0] TempSpan = 15'd17500;
  localparam logic [SpanW-1:0] HumSpan  = 15'd10000;
  localparam logic signed [RawW:0] TempOffset = 17'sd4500;

  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic             crc_ok;
  } htfd_lane_t;

  // crc-8, msb first, one byte
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc_in,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < ByteW; i++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(p / 65535) as (p + (p >> 16) + 1) >> 16
  function automatic logic [RawW-1:0] div_full_scale(input logic [ProdW-1:0] p);
    logic [ProdW:0] s;
    s = {1'b0, p} + (ProdW+1)'(p >> RawW) + (ProdW+1)'(1);
    return s[ProdW -: RawW];
  endfunction

endpackage

// ----- design/htfd_if.sv -----
interface htfd_frame_if;
  import htfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] temp_msb;
  logic [ByteW-1:0] temp_lsb;
  logic [ByteW-1:0] temp_check;
  logic [ByteW-1:0] hum_msb;
  logic [ByteW-1:0] hum_lsb;
  logic [ByteW-1:0] hum_check;

  modport source (output valid, temp_msb, temp_lsb, temp_check, hum_msb, hum_lsb,
                  hum_check, input ready);
  modport sink (input valid, temp_msb, temp_lsb, temp_check, hum_msb, hum_lsb,
                hum_check, output ready);
endinterface

interface htfd_result_if;
  import htfd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temp_centi;
  logic [HumW-1:0]         hum_centi;
  logic                    temp_crc_ok;
  logic                    hum_crc_ok;

  modport source (output valid, temp_centi, hum_centi, temp_crc_ok, hum_crc_ok,
                  input ready);
  modport sink (input valid, temp_centi, hum_centi, temp_crc_ok, hum_crc_ok,
                output ready);
endinterface

// ----- design/htfd_lane.sv -----
module htfd_lane
  import htfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ByteW-1:0] msb_i,
  input  logic [ByteW-1:0] lsb_i,
  input  logic [ByteW-1:0] check_i,
  input  logic [SpanW-1:0] span_i,
  output htfd_lane_t       res_o
);

  logic [RawW-1:0]  raw;
  logic [ByteW-1:0] crc;
  htfd_lane_t       res_d, res_q;

  always_comb begin
    raw          = {msb_i, lsb_i};
    crc          = crc8_byte(crc8_byte(CrcInit, msb_i), lsb_i);
    res_d.prod   = ProdW'(raw) * ProdW'(span_i);
    res_d.crc_ok = (crc == check_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- design/htfd_merge.sv -----
module htfd_merge
  import htfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  htfd_lane_t           temp_i,
  input  htfd_lane_t           hum_i,
  htfd_result_if.source        result_o
);

  logic                    valid_q;
  logic [RawW-1:0]         temp_q16;
  logic [RawW-1:0]         hum_q16;
  logic signed [RawW:0]    temp_full;
  logic signed [TempW-1:0] temp_d, temp_q;
  logic [HumW-1:0]         hum_d, hum_q;
  logic                    temp_ok_q, hum_ok_q;

  assign ready_o = !valid_q || result_o.ready;

  always_comb begin
    temp_q16  = div_full_scale(temp_i.prod);
    hum_q16   = div_full_scale(hum_i.prod);
    temp_full = $signed({1'b0, temp_q16}) - TempOffset;
    temp_d    = temp_full[TempW-1:0];
    hum_d     = hum_q16[HumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      temp_q    <= temp_d;
      hum_q     <= hum_d;
      temp_ok_q <= temp_i.crc_ok;
      hum_ok_q  <= hum_i.crc_ok;
    end
  end

  assign result_o.valid       = valid_q;
  assign result_o.temp_centi  = temp_q;
  assign result_o.hum_centi   = hum_q;
  assign result_o.temp_crc_ok = temp_ok_q;
  assign result_o.hum_crc_ok  = hum_ok_q;

endmodule

// ----- design/humidity_temp_frame_decode_core.sv -----
// pipeline: an accepted frame word is registered in the lane stage, then in the merge stage
// throughput: one word per cycle while result_o.ready holds; each lane holds the
// multiplier and the merge stage holds the divide-by-65535 correction
// reset: asynchronous, active low; clears both stage valid flags, data is not reset
module humidity_temp_frame_decode_core
  import htfd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  htfd_frame_if.sink    frame_i,
  htfd_result_if.source result_o
);

  logic       v1_q;
  logic       s1_rdy;
  logic       m_rdy;
  logic       accept;
  htfd_lane_t temp_lane, hum_lane;

  assign s1_rdy        = !v1_q || m_rdy;
  assign frame_i.ready = s1_rdy;
  assign accept        = frame_i.valid && s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s1_rdy) begin
      v1_q <= frame_i.valid;
    end
  end

  htfd_lane u_temp_lane (
    .clk_i   (clk_i),
    .en_i    (accept),
    .msb_i   (frame_i.temp_msb),
    .lsb_i   (frame_i.temp_lsb),
    .check_i (frame_i.temp_check),
    .span_i  (TempSpan),
    .res_o   (temp_lane)
  );

  htfd_lane u_hum_lane (
    .clk_i   (clk_i),
    .en_i    (accept),
    .msb_i   (frame_i.hum_msb),
    .lsb_i   (frame_i.hum_lsb),
    .check_i (frame_i.hum_check),
    .span_i  (HumSpan),
    .res_o   (hum_lane)
  );

  htfd_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v1_q),
    .ready_o  (m_rdy),
    .temp_i   (temp_lane),
    .hum_i    (hum_lane),
    .result_o (result_o)
  );

`ifndef ASSERT_OFF
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted word not in lane stage");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !m_rdy |=> v1_q)
    else $error("lane stage word dropped while stalled");
  a_moves_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && m_rdy |=> result_o.valid)
    else $error("lane stage word not passed to output");
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q && (!result_o.valid || result_o.ready) |=> !result_o.valid)
    else $error("result word without a source");
`endif

endmodule

// ----- test/tb_humidity_temp_frame_decode_core.sv -----
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decode_core;
  import htfd_pkg::*;

  localparam int unsigned FullScale  = 65535;
  localparam int unsigned TempScale  = 17500;
  localparam int          TempShift  = 4500;
  localparam int unsigned HumScale   = 10000;
  localparam logic [7:0]  Crc8Poly   = 8'h31;
  localparam logic [7:0]  Crc8Seed   = 8'hFF;
  localparam int          HoldCycles = 150;
  localparam int          IdlePct    = 37;
  localparam int          MaxReports = 10;

  typedef enum logic [1:0] {
    CK_GOOD,
    CK_FLIP,
    CK_RANDOM
  } check_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] temp_msb;
    logic [ByteW-1:0] temp_lsb;
    logic [ByteW-1:0] temp_check;
    logic [ByteW-1:0] hum_msb;
    logic [ByteW-1:0] hum_lsb;
    logic [ByteW-1:0] hum_check;
  } frame_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp_centi;
    logic [HumW-1:0]         hum_centi;
    logic                    temp_crc_ok;
    logic                    hum_crc_ok;
  } reading_t;

  logic clk;
  logic rst_n;

  htfd_frame_if  frame_if ();
  htfd_result_if result_if ();

  humidity_temp_frame_decode_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .frame_i (frame_if),
    .result_o(result_if)
  );

  reading_t pending_readings[$];
  int       errors;
  bit       sender_idles;
  bit       receiver_stalls;
  int       hold_req;
  int       hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  // serial crc-8 over a 16-bit word, msb first
  function automatic logic [7:0] word_checksum(input logic [15:0] word);
    logic [7:0] crc;
    logic       fb;
    crc = Crc8Seed;
    for (int i = 15; i >= 0; i--) begin
      fb  = crc[7] ^ word[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? Crc8Poly : 8'h00);
    end
    return crc;
  endfunction

  function automatic reading_t decode_reading(input frame_t f);
    reading_t    r;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    int unsigned t_scaled;
    int unsigned h_scaled;
    raw_t         = {f.temp_msb, f.temp_lsb};
    raw_h         = {f.hum_msb, f.hum_lsb};
    t_scaled      = (int'(raw_t) * TempScale) / FullScale;
    h_scaled      = (int'(raw_h) * HumScale) / FullScale;
    r.temp_centi  = TempW'(int'(t_scaled) - TempShift);
    r.hum_centi   = HumW'(h_scaled);
    r.temp_crc_ok = (word_checksum(raw_t) == f.temp_check);
    r.hum_crc_ok  = (word_checksum(raw_h) == f.hum_check);
    return r;
  endfunction

  function automatic logic [7:0] pick_check(input logic [15:0] word, input check_kind_e kind);
    logic [7:0] good;
    good = word_checksum(word);
    case (kind)
      CK_GOOD: begin
        return good;
      end
      CK_FLIP: begin
        return good ^ (8'h01 << $urandom_range(7));
      end
      default: begin
        return 8'($urandom);
      end
    endcase
  endfunction

  function automatic frame_t make_frame(input logic [15:0] raw_t, input logic [15:0] raw_h,
                                        input check_kind_e t_kind, input check_kind_e h_kind);
    frame_t f;
    {f.temp_msb, f.temp_lsb} = raw_t;
    {f.hum_msb, f.hum_lsb}   = raw_h;
    f.temp_check             = pick_check(raw_t, t_kind);
    f.hum_check              = pick_check(raw_h, h_kind);
    return f;
  endfunction

  function automatic check_kind_e random_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) begin
      return CK_GOOD;
    end else if (r < 80) begin
      return CK_FLIP;
    end
    return CK_RANDOM;
  endfunction

  function automatic logic [15:0] random_raw();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) begin
      return 16'h0000;
    end else if (r < 8) begin
      return 16'hFFFF;
    end
    return 16'($urandom);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MaxReports) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // valid stays high between back-to-back words
  task automatic send_frame(input frame_t f);
    while (sender_idles && $urandom_range(99) < IdlePct) begin
      frame_if.valid <= 1'b0;
      @(negedge clk);
    end
    frame_if.valid      <= 1'b1;
    frame_if.temp_msb   <= f.temp_msb;
    frame_if.temp_lsb   <= f.temp_lsb;
    frame_if.temp_check <= f.temp_check;
    frame_if.hum_msb    <= f.hum_msb;
    frame_if.hum_lsb    <= f.hum_lsb;
    frame_if.hum_check  <= f.hum_check;
    do begin
      @(posedge clk);
    end while (!frame_if.ready);
    pending_readings.push_back(decode_reading(f));
    @(negedge clk);
  endtask

  initial begin
    result_if.ready = 1'b0;
    hold_done       = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        result_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_done = hold_req;
      end else begin
        result_if.ready <= !receiver_stalls || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && result_if.valid && result_if.ready) begin
      if (pending_readings.size() == 0) begin
        flag_error("result word with no frame pending");
      end else begin
        want = pending_readings.pop_front();
        if (result_if.temp_centi !== want.temp_centi) begin
          flag_error($sformatf("temp_centi exp %0d got %0d", want.temp_centi,
                               result_if.temp_centi));
        end
        if (result_if.hum_centi !== want.hum_centi) begin
          flag_error($sformatf("hum_centi exp %0d got %0d", want.hum_centi,
                               result_if.hum_centi));
        end
        if (result_if.temp_crc_ok !== want.temp_crc_ok) begin
          flag_error($sformatf("temp_crc_ok exp %0b got %0b", want.temp_crc_ok,
                               result_if.temp_crc_ok));
        end
        if (result_if.hum_crc_ok !== want.hum_crc_ok) begin
          flag_error($sformatf("hum_crc_ok exp %0b got %0b", want.hum_crc_ok,
                               result_if.hum_crc_ok));
        end
      end
    end
  end

  task automatic test_scale_extremes();
    send_frame(make_frame(16'h0000, 16'h0000, CK_GOOD, CK_GOOD));
    send_frame(make_frame(16'hFFFF, 16'hFFFF, CK_GOOD, CK_GOOD));
    send_frame(make_frame(16'h0001, 16'hFFFE, CK_GOOD, CK_GOOD));
    send_frame(make_frame(16'hFFFE, 16'h0001, CK_GOOD, CK_GOOD));
    send_frame(make_frame(16'h7FFF, 16'h8000, CK_GOOD, CK_GOOD));
    send_frame(make_frame(16'h8000, 16'h7FFF, CK_GOOD, CK_GOOD));
    send_frame(make_frame(16'hBEEF, 16'h6666, CK_GOOD, CK_GOOD));
    send_frame(make_frame(16'h5555, 16'hAAAA, CK_GOOD, CK_GOOD));
  endtask

  task automatic test_crc_mismatch();
    frame_t f;
    send_frame(make_frame(16'h6666, 16'h9999, CK_FLIP, CK_GOOD));
    send_frame(make_frame(16'h6666, 16'h9999, CK_GOOD, CK_FLIP));
    send_frame(make_frame(16'h0000, 16'hFFFF, CK_FLIP, CK_FLIP));
    send_frame(make_frame(16'hFFFF, 16'h0000, CK_RANDOM, CK_RANDOM));
    f            = make_frame(16'h1234, 16'hABCD, CK_GOOD, CK_GOOD);
    f.temp_check = 8'h00;
    f.hum_check  = 8'hFF;
    send_frame(f);
    f            = make_frame(16'hFEDC, 16'h0123, CK_GOOD, CK_GOOD);
    f.temp_check = 8'hFF;
    f.hum_check  = 8'h00;
    send_frame(f);
  endtask

  task automatic test_random_frames(input int count, input bit with_idles);
    sender_idles    = with_idles;
    receiver_stalls = with_idles;
    repeat (count) begin
      send_frame(make_frame(random_raw(), random_raw(), random_kind(), random_kind()));
    end
  endtask

  // receiver holds off while frames keep coming, so the pipe fills and stalls
  task automatic test_output_backpressure();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    hold_req++;
    repeat (40) begin
      send_frame(make_frame(random_raw(), random_raw(), random_kind(), random_kind()));
    end
  endtask

  initial begin
    errors              = 0;
    hold_req            = 0;
    sender_idles        = 1'b0;
    receiver_stalls     = 1'b0;
    rst_n               = 1'b0;
    frame_if.valid      = 1'b0;
    frame_if.temp_msb   = '0;
    frame_if.temp_lsb   = '0;
    frame_if.temp_check = '0;
    frame_if.hum_msb    = '0;
    frame_if.hum_lsb    = '0;
    frame_if.hum_check  = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_scale_extremes();
    test_crc_mismatch();
    test_random_frames(300, 1'b0);
    test_random_frames(560, 1'b1);
    test_output_backpressure();
    test_random_frames(40, 1'b1);

    frame_if.valid <= 1'b0;
    while (pending_readings.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
